// ===== hw/rtl/bgf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_pkg: shared types and constants of the gradient-flow sweep
// Field and coefficient formats, register codes, unit request and response
// structs and the sequencer state types.
// ----------------------------------------------------------------------------
package bgf_pkg;

  // Field format: signed Q8.(PHI_W-8)
  localparam int PHI_W     = 32;
  localparam int PHI_FRAC  = PHI_W - 8;
  localparam int COEF_FRAC = 24;
  localparam int STEP_FRAC = 40;

  // Working value width and configuration widths
  localparam int VAL_W   = 64;
  localparam int CFG_W   = 47;
  localparam int MU_W    = 48;
  localparam int FORCE_W = 47;
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  // Divider widths: quotient stays below 2^61 since the divisor is at least one
  localparam int NUM_W = 60;
  localparam int DEN_W = 61;
  localparam int QUO_W = 61;
  localparam int REM_W = 62;

  typedef logic signed [VAL_W-1:0] sval_t;

  localparam sval_t LIM       = 64'sh0FFF_FFFF_FFFF_FFFF;
  localparam sval_t FORCE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam sval_t ONE       = sval_t'(64'd1 << PHI_FRAC);
  localparam sval_t PHI_MAX   = sval_t'((64'd1 << (PHI_W - 1)) - 64'd1);
  localparam sval_t PHI_MIN   = -sval_t'(64'd1 << (PHI_W - 1));

  // Register reset values
  localparam logic [CFG_W-1:0]       DX2_RST   = 47'd6710886400;
  localparam logic [CFG_W-1:0]       DX4_RST   = 47'd2684354560000;
  localparam logic [CFG_W-1:0]       BETA_RST  = 47'd16777216;
  localparam logic [CFG_W-1:0]       M2_RST    = 47'd16777216;
  localparam logic signed [MU_W-1:0] MU_RST    = -48'sd838860800;
  localparam logic [CFG_W-1:0]       KAPPA_RST = 47'd16777216;
  localparam logic [CFG_W-1:0]       DT_RST    = 47'd215504;

  // Register indexes (byte address / 8)
  localparam logic [2:0] REG_DX2   = 3'd0;
  localparam logic [2:0] REG_DX4   = 3'd1;
  localparam logic [2:0] REG_BETA  = 3'd2;
  localparam logic [2:0] REG_M2    = 3'd3;
  localparam logic [2:0] REG_MU    = 3'd4;
  localparam logic [2:0] REG_KAPPA = 3'd5;
  localparam logic [2:0] REG_DT    = 3'd6;

  // Rounding shift of a product
  typedef enum logic [1:0] {SH_COEF, SH_PHI, SH_STEP} shsel_t;

  typedef struct packed {
    logic   start;
    shsel_t sh;
    sval_t  a;
    sval_t  b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    logic  sat;
    sval_t res;
  } unit_rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_EMIT} state_t;

  typedef enum logic [3:0] {
    OP_LAP, OP_BH, OP_BT, OP_MT, OP_P2, OP_P4, OP_P5, OP_P6,
    OP_KD, OP_D2, OP_NUM, OP_DIV, OP_UPD
  } op_t;

  function automatic logic [VAL_W-1:0] mag64(sval_t v);
    return v[VAL_W-1] ? unsigned'(-v) : unsigned'(v);
  endfunction

endpackage

// ===== hw/rtl/bgf_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_ifs: request channels of the gradient-flow sweep
// Sample channel in, updated-sample channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgf_in_if;
  import bgf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PHI_W-1:0] phi_in;
  logic                    last_in;

  modport source (output valid, phi_in, last_in, input ready);
  modport sink   (input valid, phi_in, last_in, output ready);
endinterface

interface bgf_out_if;
  import bgf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PHI_W-1:0] phi_out;
  logic                    is_last;
  logic [PHI_W-2:0]        peak_abs;
  logic [FORCE_W-1:0]      max_force_abs;
  logic                    overflow;

  modport source (output valid, phi_out, is_last, peak_abs, max_force_abs, overflow,
                  input ready);
  modport sink   (input valid, phi_out, is_last, peak_abs, max_force_abs, overflow,
                  output ready);
endinterface

// ===== hw/rtl/bgf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_mul: shared rounding multiplier
// Sign-magnitude product of two 64-bit values from four 32x32 partial
// products, rounded half away from zero and clamped to +-(2^60-1).
// ----------------------------------------------------------------------------
module bgf_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  bgf_pkg::mul_req_t   req,
  output bgf_pkg::unit_rsp_t  rsp
);
  import bgf_pkg::*;

  localparam logic [2:0] LAST_PP  = 3'd3;
  localparam logic [2:0] FIRST_AC = 3'd1;
  localparam logic [2:0] LAST_AC  = 3'd4;
  localparam logic [2:0] RND_CNT  = 3'd5;

  logic             busy_r;
  logic             done_r;
  logic [2:0]       cnt_r;
  logic [VAL_W-1:0] ma_r;
  logic [VAL_W-1:0] mb_r;
  logic             neg_r;
  shsel_t           sh_r;
  logic [63:0]      pp_r;
  logic [1:0]       psh_r;
  logic [127:0]     acc_r;
  sval_t            res_r;
  logic             sat_r;

  logic [31:0]  xa;
  logic [31:0]  xb;
  logic [63:0]  prod;
  logic [1:0]   psh;
  logic [127:0] shifted;
  logic [127:0] rnd;
  logic [127:0] rsh;
  logic         sat;
  sval_t        mres;

  // Select the partial product for this phase
  always_comb begin
    xa      = cnt_r[0] ? ma_r[63:32] : ma_r[31:0];
    xb      = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    prod    = 64'(xa) * 64'(xb);
    psh     = 2'(cnt_r[0]) + 2'(cnt_r[1]);
    shifted = {64'd0, pp_r} << {psh_r, 5'd0};
  end

  // Round, shift and clamp the full product
  always_comb begin
    case (sh_r)
      SH_COEF: begin
        rnd = acc_r + (128'd1 << (COEF_FRAC - 1));
        rsh = rnd >> COEF_FRAC;
      end
      SH_PHI: begin
        rnd = acc_r + (128'd1 << (PHI_FRAC - 1));
        rsh = rnd >> PHI_FRAC;
      end
      SH_STEP: begin
        rnd = acc_r + (128'd1 << (STEP_FRAC - 1));
        rsh = rnd >> STEP_FRAC;
      end
      default: begin
        rnd = acc_r;
        rsh = acc_r;
      end
    endcase
    sat  = |rsh[127:60];
    mres = sat ? LIM : sval_t'({4'd0, rsh[59:0]});
  end

  // Control: start, count phases, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == RND_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitudes, multiply, accumulate, round
  always_ff @(posedge clk) begin
    if (req.start) begin
      ma_r  <= mag64(req.a);
      mb_r  <= mag64(req.b);
      neg_r <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
      sh_r  <= req.sh;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= LAST_PP) begin
        pp_r  <= prod;
        psh_r <= psh;
      end
      if (cnt_r >= FIRST_AC && cnt_r <= LAST_AC) begin
        acc_r <= acc_r + shifted;
      end
      if (cnt_r == RND_CNT) begin
        res_r <= neg_r ? -mres : mres;
        sat_r <= sat;
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.res  = res_r;

endmodule

// ===== hw/rtl/bgf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgf_div: restoring divider for the potential term
// round(num * 2^PHI_FRAC / den), one quotient bit a cycle, ties round up.
// ----------------------------------------------------------------------------
module bgf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bgf_pkg::div_req_t   req,
  output bgf_pkg::unit_rsp_t  rsp
);
  import bgf_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam logic [CNT_W-1:0] RND_CNT = CNT_W'(QUO_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [QUO_W-1:0] nb_r;
  logic [QUO_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  sval_t            res_r;

  logic [REM_W-1:0] trial;
  logic             qbit;
  logic [REM_W-1:0] rem2;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_r[REM_W-2:0], nb_r[QUO_W-1]};
    qbit  = trial >= REM_W'(den_r);
    rem2  = {rem_r[REM_W-2:0], 1'b0};
  end

  // Control: start, count bits, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == RND_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle, then round to nearest
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= REM_W'(req.num >> (QUO_W - PHI_FRAC));
      nb_r  <= QUO_W'({req.num, {PHI_FRAC{1'b0}}});
      den_r <= req.den;
      q_r   <= '0;
    end else if (busy_r) begin
      if (cnt_r == RND_CNT) begin
        res_r <= sval_t'({3'd0, q_r}) + sval_t'({63'd0, rem2 >= REM_W'(den_r)});
      end else begin
        rem_r <= qbit ? trial - REM_W'(den_r) : trial;
        nb_r  <= {nb_r[QUO_W-2:0], 1'b0};
        q_r   <= {q_r[QUO_W-2:0], qbit};
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.sat  = 1'b0;
  assign rsp.res  = res_r;

endmodule

// ===== hw/rtl/biharmonic_gradient_flow_sweep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biharmonic_gradient_flow_sweep: streaming explicit gradient-flow sweep
// Five-sample window over a 1D field; each interior sample is advanced by
// dtau * (Laplacian - beta*biharmonic - m^2*phi - dV) on one shared
// multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Sequence: a sample with a full window runs eleven products on the shared
//   multiplier, a quotient in the one-bit-a-cycle divider and the update
//   product; the sequencer issues each request and waits for the unit's done.
// Flow: a new sample is accepted only once all results of the last are taken;
//   trailing zeros follow at sweep end and edge samples skip the products.
// Reset: synchronous, active low; configuration registers return to defaults, window and
//   sweep statistics clear at once.
module biharmonic_gradient_flow_sweep (
  input  logic                          clk,
  input  logic                          rst_n,
  bgf_in_if.sink                        in_ch,
  bgf_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgf_pkg::PADDR_W-1:0]   paddr,
  input  logic [bgf_pkg::PDATA_W-1:0]   pwdata,
  output logic [bgf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bgf_pkg::*;

  localparam int LS_W = PHI_W + 2;
  localparam int BS_W = PHI_W + 4;

  // Configuration registers
  logic [CFG_W-1:0]       dx2_r, dx4_r, beta_r, m2_r, kappa_r, dt_r;
  logic signed [MU_W-1:0] mu_r;

  // Sequencer and datapath registers
  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic signed [PHI_W-1:0] win_r [4];
  logic signed [PHI_W-1:0] win_nxt [4];
  logic [2:0]              fill_r, fill_nxt;
  logic signed [LS_W-1:0]  lsum_r, lsum_nxt;
  logic signed [BS_W-1:0]  bsum_r, bsum_nxt;
  sval_t                   acc_r, acc_nxt;
  sval_t                   t_r, t_nxt;
  sval_t                   p5_r, p5_nxt;
  sval_t                   d2_r, d2_nxt;
  sval_t                   num_r, num_nxt;
  logic signed [PHI_W-1:0] val_r, val_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    last_r, last_nxt;
  logic [PHI_W-2:0]        peak_r, peak_nxt;
  logic [FORCE_W-1:0]      maxf_r, maxf_nxt;
  logic                    ovf_r, ovf_nxt;

  mul_req_t  mul_req;
  div_req_t  div_req;
  unit_rsp_t mul_rsp;
  unit_rsp_t div_rsp;

  logic                    in_acc;
  logic                    out_acc;
  logic                    cfg_wr;
  logic                    unit_done;
  logic                    unit_sat;
  sval_t                   unit_res;
  logic signed [PHI_W-1:0] c;
  sval_t                   c_ext;
  sval_t                   fclamp;
  logic                    fsat;
  logic [PHI_W-1:0]        c_mag;
  logic [PHI_W-2:0]        c_peak;
  logic [FORCE_W-1:0]      f_mag;
  sval_t                   m3;
  sval_t                   nsum;
  logic [1:0]              n_out;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx2_r   <= DX2_RST;
      dx4_r   <= DX4_RST;
      beta_r  <= BETA_RST;
      m2_r    <= M2_RST;
      mu_r    <= MU_RST;
      kappa_r <= KAPPA_RST;
      dt_r    <= DT_RST;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1:3])
        REG_DX2:   dx2_r   <= pwdata[CFG_W-1:0];
        REG_DX4:   dx4_r   <= pwdata[CFG_W-1:0];
        REG_BETA:  beta_r  <= pwdata[CFG_W-1:0];
        REG_M2:    m2_r    <= pwdata[CFG_W-1:0];
        REG_MU:    mu_r    <= pwdata[MU_W-1:0];
        REG_KAPPA: kappa_r <= pwdata[CFG_W-1:0];
        REG_DT:    dt_r    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration read
  always_comb begin
    case (paddr[PADDR_W-1:3])
      REG_DX2:   prdata = PDATA_W'(dx2_r);
      REG_DX4:   prdata = PDATA_W'(dx4_r);
      REG_BETA:  prdata = PDATA_W'(beta_r);
      REG_M2:    prdata = PDATA_W'(m2_r);
      REG_MU:    prdata = PDATA_W'(mu_r);
      REG_KAPPA: prdata = PDATA_W'(kappa_r);
      REG_DT:    prdata = PDATA_W'(dt_r);
      default:   prdata = '0;
    endcase
  end

  // Shared units
  bgf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  bgf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign unit_done = (op_r == OP_DIV) ? div_rsp.done : mul_rsp.done;
  assign unit_sat  = (op_r == OP_DIV) ? div_rsp.sat  : mul_rsp.sat;
  assign unit_res  = (op_r == OP_DIV) ? div_rsp.res  : mul_rsp.res;

  // Centre sample, force clamp and helpers
  always_comb begin
    c     = win_r[1];
    c_ext = VAL_W'(c);
    fsat  = 1'b0;
    if (acc_r > FORCE_MAX) begin
      fclamp = FORCE_MAX;
      fsat   = 1'b1;
    end else if (acc_r < -FORCE_MAX) begin
      fclamp = -FORCE_MAX;
      fsat   = 1'b1;
    end else begin
      fclamp = acc_r;
    end
    f_mag  = FORCE_W'(mag64(fclamp));
    c_mag  = c[PHI_W-1] ? unsigned'(-c) : unsigned'(c);
    c_peak = c_mag[PHI_W-1] ? '1 : c_mag[PHI_W-2:0];
    m3     = (mul_rsp.res <<< 1) + mul_rsp.res;
    nsum   = c_ext + mul_rsp.res;
  end

  // Operand selection for the shared units
  always_comb begin
    mul_req.start = (state_r == ST_ISSUE) && (op_r != OP_DIV);
    mul_req.sh    = SH_COEF;
    mul_req.a     = c_ext;
    mul_req.b     = c_ext;
    case (op_r)
      OP_LAP: begin
        mul_req.a = VAL_W'(lsum_r);
        mul_req.b = sval_t'({17'd0, dx2_r});
      end
      OP_BH: begin
        mul_req.a = VAL_W'(bsum_r);
        mul_req.b = sval_t'({17'd0, dx4_r});
      end
      OP_BT: begin
        mul_req.a = t_r;
        mul_req.b = sval_t'({17'd0, beta_r});
      end
      OP_MT: mul_req.b = sval_t'({17'd0, m2_r});
      OP_P2: mul_req.sh = SH_PHI;
      OP_P4: begin
        mul_req.sh = SH_PHI;
        mul_req.a  = t_r;
        mul_req.b  = t_r;
      end
      OP_P5: begin
        mul_req.sh = SH_PHI;
        mul_req.a  = t_r;
      end
      OP_P6: begin
        mul_req.sh = SH_PHI;
        mul_req.a  = p5_r;
      end
      OP_KD: begin
        mul_req.a = t_r;
        mul_req.b = sval_t'({17'd0, kappa_r});
      end
      OP_D2: begin
        mul_req.sh = SH_PHI;
        mul_req.a  = t_r;
        mul_req.b  = t_r;
      end
      OP_NUM: begin
        mul_req.a = p5_r;
        mul_req.b = VAL_W'(mu_r);
      end
      OP_UPD: begin
        mul_req.sh = SH_STEP;
        mul_req.a  = fclamp;
        mul_req.b  = sval_t'({17'd0, dt_r});
      end
      default: ;
    endcase
    div_req.start = (state_r == ST_ISSUE) && (op_r == OP_DIV);
    div_req.num   = NUM_W'(mag64(num_r));
    div_req.den   = d2_r[DEN_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (fill_r >= 3'd4) begin
            state_nxt = ST_ISSUE;
          end else if (n_out != 2'd0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (unit_done) begin
          state_nxt = (op_r == OP_UPD) ? ST_EMIT : ST_ISSUE;
        end
      end
      ST_EMIT: begin
        if (out_acc && cnt_r == 2'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ch.ready          = (state_r == ST_IDLE);
    out_ch.valid         = (state_r == ST_EMIT);
    out_ch.phi_out       = val_r;
    out_ch.is_last       = last_r && (cnt_r == 2'd1);
    out_ch.peak_abs      = out_ch.is_last ? peak_r : '0;
    out_ch.max_force_abs = out_ch.is_last ? maxf_r : '0;
    out_ch.overflow      = ovf_r;
  end

  // Result count of the accepted sample: one from the third sample on, zeros at the end
  always_comb begin
    n_out = 2'(fill_r >= 3'd2);
    if (in_ch.last_in) begin
      n_out = n_out + ((fill_r != 3'd0) ? 2'd2 : 2'd1);
    end
  end

  // Datapath next values
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    lsum_nxt = lsum_r;
    bsum_nxt = bsum_r;
    acc_nxt  = acc_r;
    t_nxt    = t_r;
    p5_nxt   = p5_r;
    d2_nxt   = d2_r;
    num_nxt  = num_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    peak_nxt = peak_r;
    maxf_nxt = maxf_r;
    ovf_nxt  = ovf_r;
    op_nxt   = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Stencil sums, then shift the window
          lsum_nxt = LS_W'(win_r[1]) - (LS_W'(win_r[2]) <<< 1) + LS_W'(win_r[3]);
          bsum_nxt = BS_W'(win_r[0]) - (BS_W'(win_r[1]) <<< 2)
                   + (BS_W'(win_r[2]) <<< 2) + (BS_W'(win_r[2]) <<< 1)
                   - (BS_W'(win_r[3]) <<< 2) + BS_W'(in_ch.phi_in);
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = win_r[3];
          win_nxt[3] = in_ch.phi_in;
          if (in_ch.last_in) begin
            fill_nxt = '0;
          end else if (fill_r < 3'd4) begin
            fill_nxt = fill_r + 3'd1;
          end
          cnt_nxt  = n_out;
          last_nxt = in_ch.last_in;
          val_nxt  = '0;
          op_nxt   = OP_LAP;
        end
      end
      ST_ISSUE: begin
        // Commit the clamped force before the update product
        if (op_r == OP_UPD) begin
          acc_nxt = fclamp;
          ovf_nxt = ovf_r | fsat;
          if (f_mag > maxf_r) begin
            maxf_nxt = f_mag;
          end
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          ovf_nxt = ovf_r | unit_sat;
          op_nxt  = op_t'(op_r + 4'd1);
          case (op_r)
            OP_LAP: acc_nxt = unit_res;
            OP_BH:  t_nxt   = unit_res;
            OP_BT:  acc_nxt = acc_r - unit_res;
            OP_MT:  acc_nxt = acc_r - unit_res;
            OP_P2:  t_nxt   = unit_res;
            OP_P4:  t_nxt   = unit_res;
            OP_P5:  p5_nxt  = unit_res;
            OP_P6:  t_nxt   = unit_res;
            OP_KD:  t_nxt   = ONE + unit_res;
            OP_D2:  d2_nxt  = unit_res;
            OP_NUM: begin
              if (m3 > LIM) begin
                num_nxt = LIM;
                ovf_nxt = 1'b1;
              end else if (m3 < -LIM) begin
                num_nxt = -LIM;
                ovf_nxt = 1'b1;
              end else begin
                num_nxt = m3;
              end
            end
            OP_DIV: begin
              acc_nxt = num_r[VAL_W-1] ? acc_r + unit_res : acc_r - unit_res;
            end
            OP_UPD: begin
              if (nsum > PHI_MAX) begin
                val_nxt = PHI_MAX[PHI_W-1:0];
                ovf_nxt = 1'b1;
              end else if (nsum < PHI_MIN) begin
                val_nxt = PHI_MIN[PHI_W-1:0];
                ovf_nxt = 1'b1;
              end else begin
                val_nxt = nsum[PHI_W-1:0];
              end
              if (c_peak > peak_r) begin
                peak_nxt = c_peak;
              end
              op_nxt = op_r;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        // Drain results; trailing ones are zero, clear stats after the last
        if (out_acc) begin
          cnt_nxt = cnt_r - 2'd1;
          val_nxt = '0;
          if (cnt_r == 2'd1 && last_r) begin
            peak_nxt = '0;
            maxf_nxt = '0;
            ovf_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_LAP;
      win_r   <= '{default: '0};
      fill_r  <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      peak_r  <= '0;
      maxf_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      peak_r  <= peak_nxt;
      maxf_r  <= maxf_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lsum_r <= lsum_nxt;
    bsum_r <= bsum_nxt;
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
    p5_r   <= p5_nxt;
    d2_r   <= d2_nxt;
    num_r  <= num_nxt;
    val_r  <= val_nxt;
  end

  // Checks
  a_centre_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fill_r >= 3'd4 |=> state_r == ST_ISSUE && op_r == OP_LAP)
    else $error("centre sample did not start the product sequence");

  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req.start |-> !mul_rsp.busy && !div_rsp.busy)
    else $error("unit started while busy");

  a_stats_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_ch.is_last |=> !ovf_r && peak_r == '0 && maxf_r == '0)
    else $error("sweep statistics not cleared after final result");

  a_no_request_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> !in_ch.ready && !out_ch.valid)
    else $error("handshake active while a product is in flight");

endmodule
